FILE: src/lpp_pkg.sv
// Shared types, constants and helpers for the length-prefixed packet packer.
package lpp_pkg;

    localparam int HEADER_BYTES = 20;
    localparam int OFFSET_BITS  = 40;
    localparam int PREFIX_BYTES = 2;
    localparam int OUT_OFFSET_W = 40;
    localparam int SEQ_W        = 64;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 64;
    localparam int MAX_RES      = 4;
    localparam int RES_CNT_W    = $clog2(MAX_RES + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_PACKET_CAPACITY = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_START_SEQUENCE  = CFG_IDX_W'(1);

    localparam logic [15:0]      CAPACITY_RESET    = 16'd1400;
    localparam logic [SEQ_W-1:0] START_SEQ_RESET   = SEQ_W'(1);
    localparam logic [15:0]      END_SESSION_COUNT = 16'hFFFF;
    localparam logic [15:0]      HEADER_LEN        = 16'(HEADER_BYTES);

    typedef enum logic [2:0] {
        KIND_RECORD       = 3'd0,
        KIND_PACKET       = 3'd1,
        KIND_END_SESSION  = 3'd2,
        KIND_TRUNC_PREFIX = 3'd3,
        KIND_TRUNC_BODY   = 3'd4,
        KIND_OVERSIZE     = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t                   kind;
        logic [SEQ_W-1:0]        seq;
        logic [15:0]             count;
        logic [15:0]             bytes;
        logic [OUT_OFFSET_W-1:0] offset;
        logic                    last;
    } result_t;

    // All results caused by one accepted byte, in delivery order.
    typedef struct packed {
        result_t [MAX_RES-1:0] slot;
        logic [RES_CNT_W-1:0]  n;
    } burst_t;

    function automatic result_t make_result(
        input kind_t                  kind,
        input logic [SEQ_W-1:0]       seq,
        input logic [15:0]            count,
        input logic [15:0]            bytes,
        input logic [OFFSET_BITS-1:0] offset
    );
        result_t r;
        r.kind   = kind;
        r.seq    = seq;
        r.count  = count;
        r.bytes  = bytes;
        r.offset = OUT_OFFSET_W'(offset);
        r.last   = 1'b0;
        return r;
    endfunction

endpackage

FILE: src/lpp_parse.sv
// Prefix/body parser, packet fill tracking and configuration registers.
module lpp_parse (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [lpp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lpp_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic                             s_fire,
    input  logic [7:0]                       s_data_byte,
    input  logic                             s_end_of_file,
    output lpp_pkg::burst_t                  burst
);

    typedef enum logic [1:0] {
        PH_PFX_HI = 2'd0,
        PH_PFX_LO = 2'd1,
        PH_BODY   = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    phase_t                            phase_reg, phase_next;
    logic [7:0]                        prefix_high_reg, prefix_high_next;
    logic [15:0]                       body_rem_reg, body_rem_next;
    logic [15:0]                       held_len_reg, held_len_next;
    logic [lpp_pkg::OFFSET_BITS-1:0]   byte_off_reg, byte_off_next;
    logic [lpp_pkg::OFFSET_BITS-1:0]   msg_start_reg, msg_start_next;
    logic [lpp_pkg::SEQ_W-1:0]         next_seq_reg, next_seq_next;
    logic [lpp_pkg::SEQ_W-1:0]         first_seq_reg, first_seq_next;
    logic [15:0]                       pkt_msgs_reg, pkt_msgs_next;
    logic [15:0]                       pkt_used_reg, pkt_used_next;
    logic                              err_reg, err_next;
    logic [15:0]                       cap_reg, cap_next;

    lpp_pkg::burst_t                   bl;
    logic [lpp_pkg::RES_CNT_W-1:0]     n_m1;
    logic                              complete;
    logic [15:0]                       len_c;
    logic [15:0]                       rem_dec;
    logic [lpp_pkg::OFFSET_BITS-1:0]   msg_off;
    logic [16:0]                       total;
    logic                              too_big;
    logic                              no_room;
    logic [15:0]                       msgs_base;
    logic [15:0]                       used_base;
    logic [lpp_pkg::SEQ_W-1:0]         first_base;
    logic [lpp_pkg::SEQ_W-1:0]         seq_inc;

    always_comb begin
        phase_next       = phase_reg;
        prefix_high_next = prefix_high_reg;
        body_rem_next    = body_rem_reg;
        held_len_next    = held_len_reg;
        byte_off_next    = byte_off_reg;
        msg_start_next   = msg_start_reg;
        next_seq_next    = next_seq_reg;
        first_seq_next   = first_seq_reg;
        pkt_msgs_next    = pkt_msgs_reg;
        pkt_used_next    = pkt_used_reg;
        err_next         = err_reg;
        cap_next         = cap_reg;

        bl         = '0;
        complete   = 1'b0;
        len_c      = held_len_reg;
        rem_dec    = body_rem_reg - 16'd1;
        msg_off    = msg_start_reg;
        msgs_base  = pkt_msgs_reg;
        used_base  = pkt_used_reg;
        first_base = first_seq_reg;
        seq_inc    = next_seq_reg + lpp_pkg::SEQ_W'(1);

        if (s_fire && !err_reg && phase_reg != PH_DONE) begin
            byte_off_next = byte_off_reg + lpp_pkg::OFFSET_BITS'(1);
            unique case (phase_reg)
                PH_PFX_HI: begin
                    msg_start_next   = byte_off_reg;
                    msg_off          = byte_off_reg;
                    prefix_high_next = s_data_byte;
                    phase_next       = PH_PFX_LO;
                    if (s_end_of_file) begin
                        err_next = 1'b1;
                        bl.slot[bl.n[1:0]] = lpp_pkg::make_result(lpp_pkg::KIND_TRUNC_PREFIX,
                            next_seq_reg, 16'd0, 16'd0, msg_off);
                        bl.n = bl.n + 1'b1;
                    end
                end
                PH_PFX_LO: begin
                    len_c         = {prefix_high_reg, s_data_byte};
                    held_len_next = len_c;
                    if (len_c == 16'd0) begin
                        complete = 1'b1;
                    end else begin
                        body_rem_next = len_c;
                        phase_next    = PH_BODY;
                        if (s_end_of_file) begin
                            err_next = 1'b1;
                            bl.slot[bl.n[1:0]] = lpp_pkg::make_result(
                                lpp_pkg::KIND_TRUNC_BODY, next_seq_reg, 16'd0, 16'd0, msg_off);
                            bl.n = bl.n + 1'b1;
                        end
                    end
                end
                PH_BODY: begin
                    body_rem_next = rem_dec;
                    if (rem_dec == 16'd0) begin
                        complete = 1'b1;
                    end else if (s_end_of_file) begin
                        err_next = 1'b1;
                        bl.slot[bl.n[1:0]] = lpp_pkg::make_result(lpp_pkg::KIND_TRUNC_BODY,
                            next_seq_reg, 16'd0, 16'd0, msg_off);
                        bl.n = bl.n + 1'b1;
                    end
                end
                PH_DONE: begin
                end
            endcase
        end

        // Whole message in hand: fit it into the open packet or a fresh one.
        total   = {1'b0, len_c} + 17'(lpp_pkg::PREFIX_BYTES);
        too_big = ({1'b0, total} + 18'(lpp_pkg::HEADER_BYTES)) > {2'b00, cap_reg};
        no_room = ({2'b00, pkt_used_reg} + {1'b0, total}) > {2'b00, cap_reg};

        if (complete) begin
            phase_next = PH_PFX_HI;
            if (too_big) begin
                if (pkt_msgs_reg != 16'd0) begin
                    bl.slot[bl.n[1:0]] = lpp_pkg::make_result(lpp_pkg::KIND_PACKET,
                        first_seq_reg, pkt_msgs_reg, pkt_used_reg, '0);
                    bl.n = bl.n + 1'b1;
                end
                pkt_msgs_next = 16'd0;
                pkt_used_next = lpp_pkg::HEADER_LEN;
                err_next      = 1'b1;
                bl.slot[bl.n[1:0]] = lpp_pkg::make_result(lpp_pkg::KIND_OVERSIZE,
                    next_seq_reg, 16'd0, 16'd0, msg_off);
                bl.n = bl.n + 1'b1;
            end else begin
                if (no_room) begin
                    if (pkt_msgs_reg != 16'd0) begin
                        bl.slot[bl.n[1:0]] = lpp_pkg::make_result(lpp_pkg::KIND_PACKET,
                            first_seq_reg, pkt_msgs_reg, pkt_used_reg, '0);
                        bl.n = bl.n + 1'b1;
                    end
                    msgs_base = 16'd0;
                    used_base = lpp_pkg::HEADER_LEN;
                end
                if (msgs_base == 16'd0) begin
                    first_base = next_seq_reg;
                end
                bl.slot[bl.n[1:0]] = lpp_pkg::make_result(lpp_pkg::KIND_RECORD,
                    next_seq_reg, 16'd0, 16'd0, msg_off);
                bl.n = bl.n + 1'b1;
                next_seq_next  = seq_inc;
                first_seq_next = first_base;
                pkt_msgs_next  = msgs_base + 16'd1;
                pkt_used_next  = used_base + total[15:0];
                if (s_end_of_file) begin
                    bl.slot[bl.n[1:0]] = lpp_pkg::make_result(lpp_pkg::KIND_PACKET,
                        first_base, msgs_base + 16'd1, used_base + total[15:0], '0);
                    bl.n = bl.n + 1'b1;
                    bl.slot[bl.n[1:0]] = lpp_pkg::make_result(lpp_pkg::KIND_END_SESSION,
                        seq_inc, lpp_pkg::END_SESSION_COUNT, lpp_pkg::HEADER_LEN, '0);
                    bl.n = bl.n + 1'b1;
                    pkt_msgs_next = 16'd0;
                    pkt_used_next = lpp_pkg::HEADER_LEN;
                    phase_next    = PH_DONE;
                end
            end
        end

        n_m1 = bl.n - 1'b1;
        if (bl.n != '0) begin
            bl.slot[n_m1[1:0]].last = 1'b1;
        end

        // Start sequence only takes effect before the first byte.
        // Unmapped indexes fall through and are dropped.
        if (cfg_wr_en) begin
            if (cfg_index == lpp_pkg::CFG_PACKET_CAPACITY) begin
                cap_next = cfg_wr_data[15:0];
            end else if (cfg_index == lpp_pkg::CFG_START_SEQUENCE) begin
                if (phase_reg == PH_PFX_HI && byte_off_reg == '0 && !err_reg) begin
                    next_seq_next = cfg_wr_data;
                end
            end
        end
    end

    assign burst = bl;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_PFX_HI;
            prefix_high_reg <= 8'd0;
            body_rem_reg    <= 16'd0;
            held_len_reg    <= 16'd0;
            byte_off_reg    <= '0;
            msg_start_reg   <= '0;
            next_seq_reg    <= lpp_pkg::START_SEQ_RESET;
            first_seq_reg   <= lpp_pkg::START_SEQ_RESET;
            pkt_msgs_reg    <= 16'd0;
            pkt_used_reg    <= lpp_pkg::HEADER_LEN;
            err_reg         <= 1'b0;
            cap_reg         <= lpp_pkg::CAPACITY_RESET;
        end else begin
            phase_reg       <= phase_next;
            prefix_high_reg <= prefix_high_next;
            body_rem_reg    <= body_rem_next;
            held_len_reg    <= held_len_next;
            byte_off_reg    <= byte_off_next;
            msg_start_reg   <= msg_start_next;
            next_seq_reg    <= next_seq_next;
            first_seq_reg   <= first_seq_next;
            pkt_msgs_reg    <= pkt_msgs_next;
            pkt_used_reg    <= pkt_used_next;
            err_reg         <= err_next;
            cap_reg         <= cap_next;
        end
    end

endmodule

FILE: src/lpp_emit.sv
// Result buffer for one byte's burst plus the output register.
module lpp_emit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_fire,
    input  lpp_pkg::burst_t   burst,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output lpp_pkg::result_t  m_res
);

    lpp_pkg::result_t               slot_reg [lpp_pkg::MAX_RES];
    logic [lpp_pkg::RES_CNT_W-1:0]  rem_reg, rem_next;
    logic                           out_valid_reg, out_valid_next;
    lpp_pkg::result_t               out_res_reg;
    logic                           pop;

    // Head slot moves to the output register whenever that register frees up.
    assign pop     = (rem_reg != '0) && (!out_valid_reg || m_ready);
    assign s_ready = (rem_reg == '0) || ((rem_reg == lpp_pkg::RES_CNT_W'(1)) && pop);

    always_comb begin
        if (s_fire) begin
            rem_next = burst.n;
        end else if (pop) begin
            rem_next = rem_reg - 1'b1;
        end else begin
            rem_next = rem_reg;
        end
        if (pop) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_res_reg <= slot_reg[0];
        end
        if (s_fire) begin
            for (int i = 0; i < lpp_pkg::MAX_RES; i++) begin
                slot_reg[i] <= burst.slot[i];
            end
        end else if (pop) begin
            for (int i = 0; i < lpp_pkg::MAX_RES - 1; i++) begin
                slot_reg[i] <= slot_reg[i+1];
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_res   = out_res_reg;

endmodule

FILE: src/length_prefixed_packet_packer.sv
// Top level of the length-prefixed packet packer.
//
// Takes a message file one byte per request (2-byte big-endian length, then
// the body) and reports, per message, an index record (sequence number and
// offset of its length prefix). Messages are packed into packets of at most
// packet_capacity bytes including a 20-byte header; when a message does not
// fit, a packet-ready descriptor (first sequence, count, bytes) comes out
// ahead of that message's record. The byte flagged end_of_file closes the
// open packet and produces an end-of-session marker with the next sequence.
// Truncated prefix, truncated body and a message too large for an empty
// packet give an error result and latch; all later bytes are taken and
// dropped until reset. Rate: one byte per clock while each byte yields at
// most one result and m_ready does not stall the output. A byte yielding
// k results (k up to 4, end of file after a packet break) holds the input
// while the burst buffer drains through the single output register. Each
// result goes through the burst buffer, then the output register. The
// start_sequence register only takes effect if written before the first byte.
module length_prefixed_packet_packer (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_wr_en,
    input  logic [lpp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lpp_pkg::CFG_DATA_W-1:0]    cfg_wr_data,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_data_byte,
    input  logic                              s_end_of_file,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [2:0]                        m_kind,
    output logic [63:0]                       m_sequence_res,
    output logic [15:0]                       m_message_count,
    output logic [15:0]                       m_packet_bytes,
    output logic [39:0]                       m_file_offset,
    output logic                              m_last_result
);

    logic              s_fire;
    lpp_pkg::burst_t   burst;
    lpp_pkg::result_t  m_res;

    assign s_fire = s_valid && s_ready;

    // Parser: all state update and result building for one byte.
    lpp_parse u_parse (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_fire        (s_fire),
        .s_data_byte   (s_data_byte),
        .s_end_of_file (s_end_of_file),
        .burst         (burst)
    );

    // Emitter: holds the burst and serializes it onto the result channel.
    lpp_emit u_emit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_fire  (s_fire),
        .burst   (burst),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    assign m_kind          = m_res.kind;
    assign m_sequence_res  = m_res.seq;
    assign m_message_count = m_res.count;
    assign m_packet_bytes  = m_res.bytes;
    assign m_file_offset   = m_res.offset;
    assign m_last_result   = m_res.last;

    // Rest of a burst is already buffered, so it follows without a gap.
    a_burst_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_result) |=> m_valid)
        else $error("burst result missing after non-final result");

    // An error always ends its burst.
    a_error_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind == lpp_pkg::KIND_TRUNC_PREFIX ||
                     m_kind == lpp_pkg::KIND_TRUNC_BODY ||
                     m_kind == lpp_pkg::KIND_OVERSIZE)) |-> m_last_result)
        else $error("error result not last of its burst");

    // Packets are only announced when they hold at least one message.
    a_packet_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == lpp_pkg::KIND_PACKET) |->
            (m_message_count != 16'd0 && m_packet_bytes > lpp_pkg::HEADER_LEN))
        else $error("empty packet descriptor");

endmodule

FILE: sim/tb_length_prefixed_packet_packer.sv
// Self-checking testbench for the length-prefixed packet packer.
module tb_length_prefixed_packet_packer;
    timeunit 1ns;
    timeprecision 1ps;

    import lpp_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 11;
    // Each result passes the burst buffer, then the output register.
    localparam int SETTLE_CYCLES = 8;
    localparam longint LIMIT_CYCLES = 400_000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = CFG_START_SEQUENCE + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = '1;

    // Where the packer stands inside the length-prefixed byte stream.
    typedef enum logic [1:0] {
        PH_LEN_HI,
        PH_LEN_LO,
        PH_BODY,
        PH_CLOSED
    } parse_phase_t;

    // Ways the one session of the run can finish.
    typedef enum int {
        END_AFTER_BREAK,
        END_EMPTY_MESSAGE,
        END_CUT_PREFIX,
        END_CUT_LENGTH,
        END_CUT_BODY,
        END_OVERSIZE
    } session_end_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data   = '0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_data_byte   = '0;
    logic                  s_end_of_file = 1'b0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [2:0]            m_kind;
    logic [63:0]           m_sequence_res;
    logic [15:0]           m_message_count;
    logic [15:0]           m_packet_bytes;
    logic [39:0]           m_file_offset;
    logic                  m_last_result;

    length_prefixed_packet_packer dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_end_of_file   (s_end_of_file),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_sequence_res  (m_sequence_res),
        .m_message_count (m_message_count),
        .m_packet_bytes  (m_packet_bytes),
        .m_file_offset   (m_file_offset),
        .m_last_result   (m_last_result)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Packer model: registers and parse state, updated on each accepted
    // request, plus the queue of results still owed.
    // ------------------------------------------------------------------
    logic [15:0]            capacity_reg;
    parse_phase_t           parse_phase;
    logic [7:0]             len_high;
    logic [15:0]            msg_len;
    logic [15:0]            body_left;
    logic [OFFSET_BITS-1:0] byte_pos;
    logic [OFFSET_BITS-1:0] msg_pos;
    logic [63:0]            seq_next;
    logic [15:0]            pkt_msgs;
    logic [15:0]            pkt_used;
    bit                     session_stopped;

    result_t step_out[$];          // results of the byte being modeled
    result_t expected_results[$];  // everything the packer still owes us

    // Run bookkeeping
    bit          src_gaps      = 1'b0;
    bit          sink_stalls   = 1'b0;
    int unsigned sink_hold     = 0;
    int unsigned requests_sent = 0;
    int unsigned results_seen  = 0;
    int unsigned packets_seen  = 0;
    int unsigned mismatches    = 0;
    longint      cycle_count   = 0;
    string       session_close = "nothing";

    function automatic void restore_model();
        capacity_reg    = CAPACITY_RESET;
        parse_phase     = PH_LEN_HI;
        len_high        = '0;
        msg_len         = '0;
        body_left       = '0;
        byte_pos        = '0;
        msg_pos         = '0;
        seq_next        = START_SEQ_RESET;
        pkt_msgs        = '0;
        pkt_used        = HEADER_LEN;
        session_stopped = 1'b0;
        expected_results.delete();
    endfunction

    function automatic void add_result(input kind_t k, input logic [63:0] seq,
                                       input logic [15:0] count, input logic [15:0] pbytes,
                                       input logic [OFFSET_BITS-1:0] offset);
        result_t r;
        r.kind   = k;
        r.seq    = seq;
        r.count  = count;
        r.bytes  = pbytes;
        r.offset = OUT_OFFSET_W'(offset);
        r.last   = 1'b0;
        step_out.push_back(r);
    endfunction

    // Emits the open packet's descriptor (only if it holds a message) and
    // starts an empty one.
    function automatic void close_open_packet();
        if (pkt_msgs != 0)
            add_result(KIND_PACKET, seq_next - 64'(pkt_msgs), pkt_msgs, pkt_used, '0);
        pkt_msgs = '0;
        pkt_used = HEADER_LEN;
    endfunction

    function automatic void predict_byte(input logic [7:0] value, input logic eof);
        logic [OFFSET_BITS-1:0] here;
        int unsigned            span;
        bit                     complete;
        if (session_stopped || parse_phase == PH_CLOSED)
            return;  // dropped after an error or end of session
        step_out.delete();
        complete = 1'b0;
        here     = byte_pos;
        byte_pos = byte_pos + 1'b1;
        case (parse_phase)
            PH_LEN_HI: begin
                msg_pos     = here;
                len_high    = value;
                parse_phase = PH_LEN_LO;
                if (eof) begin
                    session_stopped = 1'b1;
                    add_result(KIND_TRUNC_PREFIX, seq_next, '0, '0, msg_pos);
                end
            end
            PH_LEN_LO: begin
                msg_len = {len_high, value};
                if (msg_len == 0) begin
                    complete = 1'b1;
                end else begin
                    body_left   = msg_len;
                    parse_phase = PH_BODY;
                    if (eof) begin
                        session_stopped = 1'b1;
                        add_result(KIND_TRUNC_BODY, seq_next, '0, '0, msg_pos);
                    end
                end
            end
            default: begin
                body_left = body_left - 1'b1;
                if (body_left == 0) begin
                    complete = 1'b1;
                end else if (eof) begin
                    session_stopped = 1'b1;
                    add_result(KIND_TRUNC_BODY, seq_next, '0, '0, msg_pos);
                end
            end
        endcase

        if (complete) begin
            span        = PREFIX_BYTES + msg_len;
            parse_phase = PH_LEN_HI;
            if (HEADER_BYTES + span > capacity_reg) begin
                // too big even for an empty packet
                close_open_packet();
                session_stopped = 1'b1;
                add_result(KIND_OVERSIZE, seq_next, '0, '0, msg_pos);
            end else begin
                if (pkt_used + span > capacity_reg)
                    close_open_packet();
                add_result(KIND_RECORD, seq_next, '0, '0, msg_pos);
                seq_next = seq_next + 1'b1;
                pkt_msgs = pkt_msgs + 1'b1;
                pkt_used = 16'(pkt_used + span);
                if (eof) begin
                    close_open_packet();
                    add_result(KIND_END_SESSION, seq_next, END_SESSION_COUNT, HEADER_LEN, '0);
                    parse_phase = PH_CLOSED;
                end
            end
        end

        if (step_out.size() != 0) begin
            step_out[step_out.size() - 1].last = 1'b1;
            foreach (step_out[i])
                expected_results.push_back(step_out[i]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Idle lengths: mostly back to back or short, now and then long.
    // ------------------------------------------------------------------
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(25, 60);
    endfunction

    // Body lengths mostly short, always small enough for an empty packet.
    function automatic int unsigned pick_length();
        int unsigned room;
        int unsigned roll;
        int unsigned len;
        room = capacity_reg - HEADER_BYTES - PREFIX_BYTES;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            len = 0;
        else if (roll < 75)
            len = $urandom_range(1, 6);
        else if (roll < 95)
            len = $urandom_range(7, 20);
        else
            len = $urandom_range(21, 48);
        return (len > room) ? room : len;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random backpressure, then every result against the model.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;  // m_ready stays low
        end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
            m_ready   <= 1'b0;
            sink_hold <= pick_gap();
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Every accepted request goes through the model at the edge it is taken.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready === 1'b1)
            predict_byte(s_data_byte, s_end_of_file);
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < 40)
            $display("[%0t] result %0d: %s got %0h, expected %0h",
                     $time, results_seen, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            results_seen++;
            if (m_kind == KIND_PACKET)
                packets_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, kind", m_kind, '0);
            end else begin
                want = expected_results.pop_front();
                if (m_kind !== want.kind)
                    report_mismatch("kind", m_kind, want.kind);
                if (m_sequence_res !== want.seq)
                    report_mismatch("sequence", m_sequence_res, want.seq);
                if (m_message_count !== want.count)
                    report_mismatch("message count", m_message_count, want.count);
                if (m_packet_bytes !== want.bytes)
                    report_mismatch("packet bytes", m_packet_bytes, want.bytes);
                if (m_file_offset !== want.offset)
                    report_mismatch("file offset", m_file_offset, want.offset);
                if (m_last_result !== want.last)
                    report_mismatch("last flag", m_last_result, want.last);
            end
        end
    end

    // Hard stop in case the packer hangs or drops a result.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("length_prefixed_packet_packer regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offers one byte and returns at the edge where it is taken. With no
    // gap, valid just stays high into the next request.
    task automatic send_byte(input logic [7:0] value, input logic eof);
        int unsigned gap;
        gap = src_gaps ? pick_gap() : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_data_byte   <= value;
        s_end_of_file <= eof;
        do @(posedge aclk); while (s_ready !== 1'b1);
        requests_sent++;
    endtask

    // Prefix, then a random body; eof_last flags the final byte.
    task automatic send_message(input int unsigned len, input bit eof_last);
        send_byte(len[15:8], 1'b0);
        send_byte(len[7:0], eof_last && len == 0);
        for (int unsigned i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, 255)), eof_last && i == len - 1);
    endtask

    // Stops sending until every owed result is out and the pipe has settled.
    // The first edge lets the model take in a byte accepted right now.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        // start_sequence reloads the counter only before the first byte
        if (idx == CFG_PACKET_CAPACITY) begin
            capacity_reg = value[15:0];
        end else if (idx == CFG_START_SEQUENCE) begin
            if (parse_phase == PH_LEN_HI && byte_pos == 0 && !session_stopped)
                seq_next = value;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset capacity; sequence loaded with all ones so it wraps at once;
    // unmapped indexes must be dropped.
    task automatic test_reset_defaults();
        write_reg(CFG_START_SEQUENCE, '0);
        write_reg(CFG_START_SEQUENCE, '1);
        write_reg(CFG_UNMAPPED_LO, 64'd22);
        write_reg(CFG_UNMAPPED_HI, 64'd22);
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        send_message(0, 1'b0);
        send_message(1, 1'b0);
        send_message(4, 1'b0);
        send_message(12, 1'b0);
    endtask

    // Smallest capacity: one empty message fills a packet, so every
    // message after the first closes the one before.
    task automatic test_min_capacity();
        wait_drained();
        write_reg(CFG_PACKET_CAPACITY, 64'd22);
        repeat (4) send_message(0, 1'b0);
    endtask

    // Largest capacity: nothing breaks, so the packet stays open across
    // messages until a later, smaller capacity forces it out.
    task automatic test_max_capacity();
        wait_drained();
        write_reg(CFG_PACKET_CAPACITY, 64'hFFFF);
        send_message(20, 1'b0);
        send_message(0, 1'b0);
        send_message(5, 1'b0);
    endtask

    // Start sequence written after traffic began must not move the counter.
    task automatic test_late_config();
        wait_drained();
        write_reg(CFG_START_SEQUENCE, {32'($urandom), 32'($urandom)});
        write_reg(CFG_UNMAPPED_HI, {32'($urandom), 32'($urandom)});
    endtask

    task automatic test_random_traffic(input int unsigned byte_budget,
                                       input int unsigned cap_lo, input int unsigned cap_hi,
                                       input bit gaps, input bit stalls);
        int unsigned stop_at;
        wait_drained();
        write_reg(CFG_PACKET_CAPACITY, 64'($urandom_range(cap_lo, cap_hi)));
        src_gaps    = gaps;
        sink_stalls = stalls;
        stop_at     = requests_sent + byte_budget;
        while (requests_sent < stop_at) begin
            if ($urandom_range(0, 19) == 0) begin
                // hold off until the packer has caught up; maybe retune
                wait_drained();
                if ($urandom_range(0, 1) == 0)
                    write_reg(CFG_PACKET_CAPACITY, 64'($urandom_range(cap_lo, cap_hi)));
            end
            send_message(pick_length(), 1'b0);
        end
    endtask

    // The session can end only once per reset, so the seed picks how.
    task automatic test_session_end();
        session_end_t how;
        int unsigned  room;
        wait_drained();
        write_reg(CFG_PACKET_CAPACITY, 64'($urandom_range(30, 80)));
        room        = capacity_reg - HEADER_BYTES - PREFIX_BYTES;
        how         = session_end_t'($urandom_range(0, 5));
        session_close = how.name();
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        case (how)
            END_AFTER_BREAK: begin
                // packet, record, packet, end of session off one byte
                send_message(3, 1'b0);
                send_message(room, 1'b1);
            end
            END_EMPTY_MESSAGE: begin
                send_message(2, 1'b0);
                send_message(0, 1'b1);
            end
            END_CUT_PREFIX: begin
                send_message(2, 1'b0);
                send_byte(8'hFF, 1'b1);
            end
            END_CUT_LENGTH: begin
                // nonzero high length byte
                send_byte(8'h01, 1'b0);
                send_byte(8'h05, 1'b1);
            end
            END_CUT_BODY: begin
                send_byte(8'h02, 1'b0);
                send_byte(8'h06, 1'b0);
                send_byte(8'($urandom_range(0, 255)), 1'b0);
                send_byte(8'($urandom_range(0, 255)), 1'b0);
                send_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            default: begin
                // open packet goes out first, then the oversize error
                send_message(1, 1'b0);
                send_message(room + 1 + $urandom_range(0, 4), 1'b0);
            end
        endcase
    endtask

    // Anything after the session is over must be swallowed silently.
    task automatic test_after_end();
        repeat (12)
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        restore_model();
        @(posedge aclk);

        test_reset_defaults();
        test_min_capacity();
        test_max_capacity();
        test_late_config();
        test_random_traffic(80, 30, 90, 1'b1, 1'b1);
        test_random_traffic(45, 100, 400, 1'b0, 1'b0);
        test_random_traffic(45, 23, 60, 1'b1, 1'b1);
        test_session_end();
        test_after_end();
        wait_drained();

        $display("covered %0d bytes, %0d results checked (%0d packet descriptors)",
                 requests_sent, results_seen, packets_seen);
        $display("capacity 22 up to 65535, sequence wrapped from all ones, session ended: %s",
                 session_close);
        if (mismatches == 0)
            $display("length_prefixed_packet_packer regression: pass");
        else
            $display("length_prefixed_packet_packer regression: fail");
        $finish;
    end

endmodule
